/* design/pfc_pkg.sv */
// pfc_pkg: sizes, codes and shared types for the partitioned convolver
// no dependencies
package pfc_pkg;

  localparam int BLOCK       = 32;
  localparam int PARTS       = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int NTAPS   = PARTS * BLOCK;
  localparam int HLEN    = (PARTS + 1) * BLOCK;
  localparam int FRAC    = SAMPLE_BITS - 1;
  localparam int TAP_AW  = $clog2(NTAPS);
  localparam int HIST_AW = $clog2(HLEN);
  localparam int FILL_W  = $clog2(BLOCK);
  localparam int ACC_W   = 2 * SAMPLE_BITS + TAP_AW;
  localparam int NP_W    = 5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_COMMIT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              we;
    logic [TAP_AW-1:0] addr;
    sample_t           data;
  } tap_wr_t;

  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] addr;
    sample_t            data;
  } hist_wr_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

/* design/pfc_in_if.sv */
// pfc_in_if: input item channel (op, tap index, value)
// depends on pfc_pkg
interface pfc_in_if;
  logic                         valid;
  logic                         ready;
  pfc_pkg::op_e                 op;
  logic [8:0]                   tap_index;
  logic signed [pfc_pkg::SAMPLE_BITS-1:0] value;

  modport source (output valid, op, tap_index, value, input ready);
  modport sink (input valid, op, tap_index, value, output ready);
endinterface

/* design/pfc_out_if.sv */
// pfc_out_if: result item channel (filtered sample and flags)
// depends on pfc_pkg
interface pfc_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [pfc_pkg::SAMPLE_BITS-1:0] out_sample;
  logic                         last;
  logic                         clipped;

  modport source (output valid, out_sample, last, clipped, input ready);
  modport sink (input valid, out_sample, last, clipped, output ready);
endinterface

/* design/pfc_cfg_if.sv */
// pfc_cfg_if: write channel for the partition count register
// depends on pfc_pkg
interface pfc_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [pfc_pkg::NP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* design/partitioned_fft_convolver.sv */
// partitioned_fft_convolver: partitioned FIR convolver, result equal to overlap-save
// The final sample of a block gives BLOCK outputs, each from a MAC pass over
// P*BLOCK taps (P = partitions in use), one coefficient/history read per cycle.
// Reset and commit: a sweep of all 2**HIST_AW (1024) history addresses clears
// history and either zeroes taps and coefficients (reset) or copies taps to the
// coefficient store (commit); no item is taken then, nor while outputs are made.
module partitioned_fft_convolver (
  input  logic  clk_i,
  input  logic  rst_ni,
  pfc_in_if.sink    in_i,
  pfc_out_if.source out_o,
  pfc_cfg_if.sink   cfg_i
);
  import pfc_pkg::*;

  state_e state_q, state_d;

  logic [HIST_AW-1:0] sw_q;
  logic               clr_mode_q;
  logic               cp_v_q, cp_z_q;
  logic [TAP_AW-1:0]  cp_a_q;
  logic [FILL_W-1:0]  fill_q;
  logic [HIST_AW-1:0] wptr_q, pos_q;
  logic [TAP_AW-1:0]  m_q, ntaps_m1_q;
  logic [FILL_W-1:0]  i_q;
  logic [NP_W-1:0]    np_q;
  logic               out_valid_q;
  sample_t            out_sample_q;
  logic               out_last_q, out_clip_q;

  logic in_acc, slot_free, block_done, sw_last, mac_last;
  logic [NP_W-1:0] np_use;
  logic [31:0]     ntaps_m1_w;

  tap_wr_t  tap_wr, coef_wr;
  hist_wr_t hist_wr;
  sample_t  tap_rd, coef_rd, hist_rd;
  mac_ctl_t mac_ctl;
  logic     mac_done, mac_clip;
  sample_t  mac_res;

  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign block_done = (in_i.op == OP_SAMPLE) && (fill_q == FILL_W'(BLOCK - 1));
  assign sw_last    = &sw_q;
  assign mac_last   = (m_q == ntaps_m1_q);

  // partitions in use, clamped to 1..PARTS
  always_comb begin
    if (np_q == '0) begin
      np_use = NP_W'(1);
    end else if (32'(np_q) > PARTS) begin
      np_use = NP_W'(PARTS);
    end else begin
      np_use = np_q;
    end
    ntaps_m1_w = 32'(np_use) * BLOCK - 1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sw_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && in_i.op == OP_COMMIT) begin
          state_d = ST_CLEAR;
        end else if (in_acc && block_done) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC:   if (mac_last) state_d = ST_DRAIN;
      ST_DRAIN: if (mac_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_d = (i_q == FILL_W'(BLOCK - 1)) ? ST_IDLE : ST_MAC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    in_i.ready   = (state_q == ST_IDLE);
    tap_wr       = '0;
    hist_wr      = '0;
    coef_wr.we   = cp_v_q;
    coef_wr.addr = cp_a_q;
    coef_wr.data = cp_z_q ? '0 : tap_rd;
    mac_ctl.valid = (state_q == ST_MAC);
    mac_ctl.first = (m_q == '0);
    mac_ctl.last  = mac_last;
    unique case (state_q)
      ST_CLEAR: begin
        tap_wr.we    = clr_mode_q && (32'(sw_q) < NTAPS);
        tap_wr.addr  = sw_q[TAP_AW-1:0];
        hist_wr.we   = 1'b1;
        hist_wr.addr = sw_q;
      end
      ST_IDLE: begin
        tap_wr.we    = in_acc && (in_i.op == OP_LOAD) && (32'(in_i.tap_index) < NTAPS);
        tap_wr.addr  = TAP_AW'(in_i.tap_index);
        tap_wr.data  = in_i.value;
        hist_wr.we   = in_acc && (in_i.op == OP_SAMPLE);
        hist_wr.addr = wptr_q;
        hist_wr.data = in_i.value;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sw_q        <= '0;
      clr_mode_q  <= 1'b1;
      cp_v_q      <= 1'b0;
      cp_z_q      <= 1'b0;
      cp_a_q      <= '0;
      fill_q      <= '0;
      wptr_q      <= '0;
      pos_q       <= '0;
      m_q         <= '0;
      i_q         <= '0;
      ntaps_m1_q  <= '0;
      np_q        <= NP_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cp_v_q  <= (state_q == ST_CLEAR) && (32'(sw_q) < NTAPS);
      cp_z_q  <= clr_mode_q;
      cp_a_q  <= sw_q[TAP_AW-1:0];
      if (cfg_i.valid && cfg_i.ready) begin
        np_q <= cfg_i.data;
      end
      if (state_q == ST_CLEAR) begin
        sw_q <= sw_q + 1'b1;
      end
      if (state_q == ST_IDLE && in_acc) begin
        if (in_i.op == OP_COMMIT) begin
          sw_q       <= '0;
          clr_mode_q <= 1'b0;
          fill_q     <= '0;
        end else if (in_i.op == OP_SAMPLE) begin
          fill_q <= fill_q + 1'b1;
          wptr_q <= wptr_q + 1'b1;
          if (block_done) begin
            pos_q      <= wptr_q - HIST_AW'(BLOCK - 1);
            m_q        <= '0;
            i_q        <= '0;
            ntaps_m1_q <= ntaps_m1_w[TAP_AW-1:0];
          end
        end
      end
      if (state_q == ST_MAC && !mac_last) begin
        m_q <= m_q + 1'b1;
      end
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
        pos_q       <= pos_q + 1'b1;
        i_q         <= i_q + 1'b1;
        m_q         <= '0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && slot_free) begin
      out_sample_q <= mac_res;
      out_clip_q   <= mac_clip;
      out_last_q   <= (i_q == FILL_W'(BLOCK - 1));
    end
  end

  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_sample_q;
  assign out_o.last       = out_last_q;
  assign out_o.clipped    = out_clip_q;

  pfc_mem u_mem (
    .clk_i        (clk_i),
    .tap_wr_i     (tap_wr),
    .tap_raddr_i  (sw_q[TAP_AW-1:0]),
    .tap_rdata_o  (tap_rd),
    .coef_wr_i    (coef_wr),
    .coef_raddr_i (m_q),
    .coef_rdata_o (coef_rd),
    .hist_wr_i    (hist_wr),
    .hist_raddr_i (pos_q - HIST_AW'(m_q)),
    .hist_rdata_o (hist_rd)
  );

  pfc_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .coef_i    (coef_rd),
    .hist_i    (hist_rd),
    .done_o    (mac_done),
    .result_o  (mac_res),
    .clipped_o (mac_clip)
  );

endmodule

/* design/pfc_mem.sv */
// pfc_mem: tap store, committed coefficient store and sample history ring
// depends on pfc_pkg; all reads registered
module pfc_mem (
  input  logic                        clk_i,
  input  pfc_pkg::tap_wr_t            tap_wr_i,
  input  logic [pfc_pkg::TAP_AW-1:0]  tap_raddr_i,
  output pfc_pkg::sample_t            tap_rdata_o,
  input  pfc_pkg::tap_wr_t            coef_wr_i,
  input  logic [pfc_pkg::TAP_AW-1:0]  coef_raddr_i,
  output pfc_pkg::sample_t            coef_rdata_o,
  input  pfc_pkg::hist_wr_t           hist_wr_i,
  input  logic [pfc_pkg::HIST_AW-1:0] hist_raddr_i,
  output pfc_pkg::sample_t            hist_rdata_o
);
  import pfc_pkg::*;

  sample_t tap_mem  [NTAPS];
  sample_t coef_mem [NTAPS];
  sample_t hist_mem [2**HIST_AW];

  // tap store
  always_ff @(posedge clk_i) begin
    if (tap_wr_i.we) begin
      tap_mem[tap_wr_i.addr] <= tap_wr_i.data;
    end
    tap_rdata_o <= tap_mem[tap_raddr_i];
  end

  // committed coefficients
  always_ff @(posedge clk_i) begin
    if (coef_wr_i.we) begin
      coef_mem[coef_wr_i.addr] <= coef_wr_i.data;
    end
    coef_rdata_o <= coef_mem[coef_raddr_i];
  end

  // sample history ring
  always_ff @(posedge clk_i) begin
    if (hist_wr_i.we) begin
      hist_mem[hist_wr_i.addr] <= hist_wr_i.data;
    end
    hist_rdata_o <= hist_mem[hist_raddr_i];
  end

endmodule

/* design/pfc_mac.sv */
// pfc_mac: multiply-accumulate datapath with rounding and saturation
// depends on pfc_pkg; consumes registered memory read data
module pfc_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfc_pkg::mac_ctl_t ctl_i,
  input  pfc_pkg::sample_t  coef_i,
  input  pfc_pkg::sample_t  hist_i,
  output logic              done_o,
  output pfc_pkg::sample_t  result_o,
  output logic              clipped_o
);
  import pfc_pkg::*;

  localparam int Y_W = ACC_W - FRAC;

  mac_ctl_t ctl1_q, ctl2_q;
  logic signed [2*SAMPLE_BITS-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic done_q;
  logic signed [ACC_W-1:0] rnd;
  logic signed [Y_W-1:0] y;
  logic hi_ok;

  // control pipeline aligned with read data and product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.valid && ctl2_q.last;
    end
  end

  // product and accumulate
  always_ff @(posedge clk_i) begin
    if (ctl1_q.valid) begin
      prod_q <= coef_i * hist_i;
    end
    if (ctl2_q.valid) begin
      acc_q <= ctl2_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd   = acc_q + ACC_W'(1 << (FRAC - 1));
    y     = Y_W'(rnd >>> FRAC);
    hi_ok = (&y[Y_W-1:SAMPLE_BITS-1]) || !(|y[Y_W-1:SAMPLE_BITS-1]);
    clipped_o = !hi_ok;
    if (hi_ok) begin
      result_o = y[SAMPLE_BITS-1:0];
    end else if (y[Y_W-1]) begin
      result_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  assign done_o = done_q;

endmodule

/* sim/tb_partitioned_fft_convolver.sv */
// tb_partitioned_fft_convolver: self-checking bench for the partitioned fft convolver
// depends on pfc_pkg, pfc_in_if, pfc_out_if, pfc_cfg_if and the block itself
// a clocked driver/monitor pair checks every output against a direct fir predictor
`timescale 1ns / 1ps

module tb_partitioned_fft_convolver;
  import pfc_pkg::*;

  localparam int  CYCLE_LIMIT  = 3000000;
  localparam int  SETTLE       = 1200;
  localparam int  HOLD_CYCLES  = 5000;
  localparam int  MAX_REPORTS  = 10;

  typedef struct {
    op_e        op;
    logic [8:0] tap_index;
    sample_t    value;
  } conv_item_t;

  typedef struct {
    sample_t out_sample;
    logic    last;
    logic    clipped;
  } conv_out_t;

  logic clk_i;
  logic rst_ni;

  pfc_in_if  in_if ();
  pfc_out_if out_if ();
  pfc_cfg_if cfg_if ();

  partitioned_fft_convolver i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // filter state mirrored by the predictor
  sample_t    flt_taps  [NTAPS];
  sample_t    flt_coefs [NTAPS];
  sample_t    flt_hist  [HLEN];
  int         flt_fill;
  logic [4:0] flt_parts;

  conv_item_t pending_items[$];
  conv_out_t  expected_outs[$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  in_fired;
  bit  pressure_on;
  bit  pressure_used;
  int  hold_left;
  int  mismatches;
  int  outs_checked;
  int  clipped_seen;
  int  items_sent;
  longint cycles;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one block of outputs: direct convolution over the partitions in use
  function automatic void emit_block();
    int     ntaps;
    int     pos;
    longint acc;
    longint y;
    conv_out_t o;
    ntaps = (flt_parts == 0) ? BLOCK :
            (flt_parts > PARTS) ? PARTS * BLOCK : flt_parts * BLOCK;
    for (int i = 0; i < BLOCK; i++) begin
      pos = HLEN - BLOCK + i;
      acc = 0;
      for (int m = 0; m < ntaps; m++)
        acc += longint'(flt_coefs[m]) * longint'(flt_hist[pos - m]);
      y = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
      o.clipped = 1'b0;
      if (y > 32767) begin
        y = 32767;
        o.clipped = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        o.clipped = 1'b1;
      end
      o.out_sample = sample_t'(y);
      o.last = (i == BLOCK - 1);
      expected_outs.push_back(o);
    end
    for (int k = 0; k < HLEN - BLOCK; k++) flt_hist[k] = flt_hist[k + BLOCK];
    for (int k = HLEN - BLOCK; k < HLEN; k++) flt_hist[k] = '0;
  endfunction

  function automatic void apply_item(conv_item_t it);
    case (it.op)
      OP_LOAD: begin
        if (it.tap_index < NTAPS) flt_taps[it.tap_index] = it.value;
      end
      OP_COMMIT: begin
        flt_coefs = flt_taps;
        foreach (flt_hist[k]) flt_hist[k] = '0;
        flt_fill = 0;
      end
      OP_SAMPLE: begin
        flt_hist[HLEN - BLOCK + flt_fill] = it.value;
        flt_fill++;
        if (flt_fill >= BLOCK) begin
          flt_fill = 0;
          emit_block();
        end
      end
      default: ;
    endcase
  endfunction

  // input driver, changes on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && !(in_if.valid && !in_fired)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.op        <= pending_items[0].op;
        in_if.tap_index <= pending_items[0].tap_index;
        in_if.value     <= pending_items[0].value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    in_fired = 1'b0;
  end

  // accepted input items feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      apply_item(pending_items.pop_front());
      items_sent++;
      in_fired = 1'b1;
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk_i) begin
    if (pressure_on && !pressure_used) begin
      hold_left     <= HOLD_CYCLES;
      pressure_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output ready, changes on the falling edge
  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && (hold_left == 0) &&
                    ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      conv_out_t want;
      if (expected_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output sample %0d last %b clipped %b",
                   out_if.out_sample, out_if.last, out_if.clipped);
      end else begin
        want = expected_outs.pop_front();
        outs_checked++;
        if (want.clipped) clipped_seen++;
        if (out_if.out_sample !== want.out_sample || out_if.last !== want.last ||
            out_if.clipped !== want.clipped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("output %0d: expected %0d/%b/%b got %0d/%b/%b", outs_checked,
                     want.out_sample, want.last, want.clipped,
                     out_if.out_sample, out_if.last, out_if.clipped);
        end
      end
    end
  end

  function automatic sample_t rand_value();
    case ($urandom_range(0, 7))
      0:       return sample_t'(16'sd32767);
      1:       return sample_t'(-16'sd32768);
      2, 3, 4: return sample_t'($urandom_range(0, 65535));
      default: return sample_t'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  task automatic queue_item(op_e op, int idx, sample_t val);
    conv_item_t it;
    it.op        = op;
    it.tap_index = idx[8:0];
    it.value     = val;
    pending_items.push_back(it);
  endtask

  task automatic write_parts(logic [4:0] np);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= np;
    do @(posedge clk_i); while (!cfg_if.ready);
    flt_parts = np;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // wait for all items taken and all outputs seen, then let the block settle
  task automatic drain();
    while (pending_items.size() != 0 || expected_outs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // mostly well-formed streams of samples, some tap edits, commits and noise
  task automatic queue_random(int count, int np);
    int span;
    int r;
    span = (np == 0) ? BLOCK : (np > PARTS) ? NTAPS : np * BLOCK;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 78)
        queue_item(OP_SAMPLE, $urandom_range(0, 511), rand_value());
      else if (r < 90)
        queue_item(OP_LOAD, ($urandom_range(0, 3) != 0) ? $urandom_range(0, span - 1)
                                                        : $urandom_range(0, 511),
                   rand_value());
      else if (r < 94)
        queue_item(OP_COMMIT, $urandom_range(0, 511), rand_value());
      else
        queue_item(OP_NONE, $urandom_range(0, 511), rand_value());
    end
  endtask

  initial begin
    logic [4:0] phase_parts [6] = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd3};
    int         phase_send  [6] = '{0, 0, 85, 0, 26, 26};
    int         phase_recv  [6] = '{0, 0, 0, 85, 26, 26};

    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = OP_LOAD;
    in_if.tap_index = '0;
    in_if.value     = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    cycles          = 0;
    hold_left       = 0;
    foreach (flt_taps[k]) begin
      flt_taps[k]  = '0;
      flt_coefs[k] = '0;
    end
    foreach (flt_hist[k]) flt_hist[k] = '0;
    flt_fill  = 0;
    flt_parts = 5'd1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extreme taps, unknown op, commit, then one block of extremes
    write_parts(5'd1);
    queue_item(OP_LOAD, 0, sample_t'(16'sd32767));
    queue_item(OP_LOAD, 1, sample_t'(-16'sd32768));
    queue_item(OP_LOAD, 511, sample_t'(-16'sd1));
    queue_item(OP_NONE, 511, sample_t'(-16'sd32768));
    queue_item(OP_COMMIT, 0, '0);
    for (int i = 0; i < BLOCK; i++)
      queue_item(OP_SAMPLE, 0, (i % 3 == 0) ? sample_t'(16'sd32767) :
                               (i % 3 == 1) ? sample_t'(-16'sd32768) : sample_t'(0));
    drain();

    // random phases across partition counts and idle patterns
    for (int p = 0; p < 6; p++) begin
      write_parts(phase_parts[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      if (p == 1) pressure_on = 1'b1;
      queue_random(85, phase_parts[p]);
      drain();
    end

    if (expected_outs.size() != 0) mismatches++;
    $display("%0d input items sent, %0d outputs checked (%0d saturated)",
             items_sent, outs_checked, clipped_seen);
    $display("partition counts 0, 1, 3, 5, 16 and 31 under four idle patterns");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pfc_pkg.sv
design/pfc_in_if.sv
design/pfc_out_if.sv
design/pfc_cfg_if.sv
design/pfc_mem.sv
design/pfc_mac.sv
design/partitioned_fft_convolver.sv
sim/tb_partitioned_fft_convolver.sv
